// ----- hdl/rre_pkg.sv -----
// Shared types, constants and a helper function of the range record encoder.
package rre_pkg;

    // Numbers sent as length-prefixed words must stay below 2^NUM_W.
    localparam int NUM_W      = 60;
    localparam int POS_W      = 63;
    localparam int WORD_W     = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_ENABLE  = 2'd1;

    // Controller states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_LOAD  = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_ERR   = 5'b10000
    } state_t;

    // Field of the record currently being sent.
    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_COUNT = 2'd1,
        PH_EXT   = 2'd2,
        PH_TAG   = 2'd3
    } phase_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic   capture;
        logic   check;
        logic   load;
        logic   shift;
        logic   err_out;
        phase_t phase;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bad;
        logic bytes_done;
        logic offset_mode;
        logic tag_enable;
    } dp_status_t;

    // Index of the highest nonzero byte above byte 0, which is the extra byte count.
    function automatic logic [2:0] extra_bytes(input logic [WORD_W-1:0] w);
        logic [2:0] n;
        n = 3'd0;
        for (int i = 1; i < 8; i++) begin
            if (w[8*i +: 8] != 8'd0) begin
                n = 3'(i);
            end
        end
        return n;
    endfunction

endpackage

// ----- hdl/rre_if.sv -----
// Channel interfaces of the range record encoder: records in, bytes out, configuration.
interface rre_rec_if;
    logic                      valid;
    logic                      ready;
    logic [rre_pkg::POS_W-1:0] position;
    logic                      high_flag;
    logic                      extension_flag;
    logic [63:0]               range_count;
    logic [63:0]               user_tag;
    logic                      restart;

    modport source (output valid, position, high_flag, extension_flag, range_count,
                    user_tag, restart, input ready);
    modport sink (input valid, position, high_flag, extension_flag, range_count,
                  user_tag, restart, output ready);
endinterface

interface rre_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic       error;

    modport source (output valid, out_byte, last, error, input ready);
    modport sink (input valid, out_byte, last, error, output ready);
endinterface

interface rre_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rre_pkg::CFG_IDX_W-1:0]  index;
    logic [rre_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/rre_ctrl.sv -----
// Controller state machine: sequences check, field loads and byte emission.
module rre_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_last,
    output logic                out_error,
    output rre_pkg::dp_cmd_t    cmd,
    input  rre_pkg::dp_status_t status
);
    import rre_pkg::*;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    phase_t after_phase;
    logic   has_after;
    logic   out_take;

    assign out_take = out_valid && out_ready;

    // Field that follows the current one, if any.
    always_comb
    begin
        after_phase = PH_TAG;
        has_after   = 1'b0;
        case (phase_reg)
            PH_FIRST:
            begin
                after_phase = PH_COUNT;
                has_after   = 1'b1;
            end
            PH_COUNT:
            begin
                if (!status.offset_mode) begin
                    after_phase = PH_EXT;
                    has_after   = 1'b1;
                end else begin
                    after_phase = PH_TAG;
                    has_after   = status.tag_enable;
                end
            end
            PH_EXT:
            begin
                after_phase = PH_TAG;
                has_after   = status.tag_enable;
            end
            PH_TAG:
            begin
                after_phase = PH_TAG;
                has_after   = 1'b0;
            end
            default:
            begin
                after_phase = PH_TAG;
                has_after   = 1'b0;
            end
        endcase
    end

    // Next state logic.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                phase_next = PH_FIRST;
                state_next = status.bad ? ST_ERR : ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_take && status.bytes_done) begin
                    if (has_after) begin
                        phase_next = after_phase;
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR:
            begin
                if (out_take) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_FIRST;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // Handshake outputs.
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT) || (state_reg == ST_ERR);
    assign out_error = (state_reg == ST_ERR);
    assign out_last  = (state_reg == ST_ERR)
                    || ((state_reg == ST_EMIT) && status.bytes_done && !has_after);

    // Datapath commands.
    assign cmd.capture = in_valid && in_ready;
    assign cmd.check   = (state_reg == ST_CHECK);
    assign cmd.load    = (state_reg == ST_LOAD);
    assign cmd.shift   = (state_reg == ST_EMIT) && out_ready && !status.bytes_done;
    assign cmd.err_out = (state_reg == ST_ERR);
    assign cmd.phase   = phase_reg;

endmodule

// ----- hdl/rre_datapath.sv -----
// Datapath: record capture, range checks, running end, configuration and byte shifter.
module rre_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [rre_pkg::POS_W-1:0]    position,
    input  logic                         high_flag,
    input  logic                         extension_flag,
    input  logic [63:0]                  range_count,
    input  logic [63:0]                  user_tag,
    input  logic                         restart,
    input  logic                         cfg_valid,
    input  logic [rre_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rre_pkg::CFG_DATA_W-1:0] cfg_data,
    input  rre_pkg::dp_cmd_t             cmd,
    output rre_pkg::dp_status_t          status,
    output logic [7:0]                   out_byte
);
    import rre_pkg::*;

    // Captured record.
    logic [POS_W-1:0]  pos_reg;
    logic              hi_reg;
    logic              ext_reg;
    logic [WORD_W-1:0] cnt_reg;
    logic [WORD_W-1:0] tag_reg;
    logic              restart_reg;

    // Configuration and running state.
    logic              offset_mode_reg;
    logic              tag_enable_reg;
    logic [WORD_W-1:0] end_reg;

    // Encoded word being sent.
    logic [NUM_W-1:0]  first_reg;
    logic [WORD_W-1:0] shift_reg;
    logic [2:0]        left_reg;

    logic [WORD_W-1:0] end_base;
    logic [WORD_W:0]   diff;
    logic [WORD_W-1:0] delta;
    logic              bad;
    logic [NUM_W-1:0]  first_val;
    logic [WORD_W-1:0] end_new;
    logic [NUM_W-1:0]  num_sel;
    logic [WORD_W-1:0] word;
    logic [2:0]        extra;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            offset_mode_reg <= 1'b0;
            tag_enable_reg  <= 1'b0;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_OFFSET_MODE) begin
                offset_mode_reg <= cfg_data[0];
            end else if (cfg_index == CFG_TAG_ENABLE) begin
                tag_enable_reg <= cfg_data[0];
            end
        end
    end

    // Record capture on an accepted transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.capture) begin
            pos_reg     <= position;
            hi_reg      <= high_flag;
            ext_reg     <= extension_flag;
            cnt_reg     <= range_count;
            tag_reg     <= user_tag;
            restart_reg <= restart;
        end
    end

    // Range checks and first number; the borrow of the subtraction flags a position below end.
    always_comb
    begin
        end_base = restart_reg ? '0 : end_reg;
        diff     = {2'b00, pos_reg} - {1'b0, end_base};
        delta    = diff[WORD_W-1:0];
        bad      = (cnt_reg[WORD_W-1:NUM_W] != '0)
                || (tag_enable_reg && (tag_reg[WORD_W-1:NUM_W] != '0));
        if (offset_mode_reg) begin
            bad       = bad || diff[WORD_W] || (delta[WORD_W-1:NUM_W-2] != '0);
            first_val = {delta[NUM_W-3:0], hi_reg, ext_reg};
            end_new   = {1'b0, pos_reg} + cnt_reg;
        end else begin
            bad       = bad || (pos_reg[POS_W-1:NUM_W-1] != '0);
            first_val = {pos_reg[NUM_W-2:0], hi_reg};
            end_new   = end_base;
        end
    end

    // Running end is committed only for a good record.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            end_reg <= '0;
        end else if (cmd.check && !bad) begin
            end_reg <= end_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check) begin
            first_reg <= first_val;
        end
    end

    // Number of the current field, shifted left by four with its byte count.
    always_comb
    begin
        case (cmd.phase)
            PH_FIRST: num_sel = first_reg;
            PH_COUNT: num_sel = cnt_reg[NUM_W-1:0];
            PH_TAG:   num_sel = tag_reg[NUM_W-1:0];
            default:  num_sel = '0;
        endcase
        word  = {num_sel, 4'b0000};
        extra = extra_bytes(word);
    end

    // Byte shifter: load a field, then move one byte out per taken transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            if (cmd.phase == PH_EXT) begin
                shift_reg <= {{(WORD_W-1){1'b0}}, ext_reg};
                left_reg  <= 3'd0;
            end else begin
                shift_reg <= {word[WORD_W-1:4], 1'b0, extra};
                left_reg  <= extra;
            end
        end else if (cmd.shift) begin
            shift_reg <= {8'd0, shift_reg[WORD_W-1:8]};
            left_reg  <= left_reg - 3'd1;
        end
    end

    assign out_byte = cmd.err_out ? 8'd0 : shift_reg[7:0];

    assign status.bad         = bad;
    assign status.bytes_done  = (left_reg == 3'd0);
    assign status.offset_mode = offset_mode_reg;
    assign status.tag_enable  = tag_enable_reg;

endmodule

// ----- hdl/range_record_encoder_top.sv -----
// Top level of the range record encoder: controller and datapath.
//
//   Channel  Role     Handshake     Payload
//   rec      sink     valid/ready   position, high_flag, extension_flag, range_count,
//                                   user_tag, restart
//   res      source   valid/ready   out_byte, last, error
//   cfg      sink     valid/ready   index, data (ready is always high)
//
// A record is accepted in IDLE and checked in CHECK; then each field is loaded in LOAD
// and its bytes are sent in EMIT, one byte per taken transaction. An erroring record
// goes from CHECK to ERR and sends one error byte. The single byte shifter bounds the rate.
// Reset is asynchronous and clears configuration and the running end to zero.
// A stalled output holds its transaction; no new record is taken until the last
// byte of the current one is taken.
module range_record_encoder_top (
    input  logic        clk,
    input  logic        rst_n,
    rre_rec_if.sink     rec,
    rre_byte_if.source  res,
    rre_cfg_if.sink     cfg
);
    import rre_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg.ready = 1'b1;

    rre_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rec.valid),
        .in_ready  (rec.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .out_last  (res.last),
        .out_error (res.error),
        .cmd       (cmd),
        .status    (status)
    );

    rre_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .position       (rec.position),
        .high_flag      (rec.high_flag),
        .extension_flag (rec.extension_flag),
        .range_count    (rec.range_count),
        .user_tag       (rec.user_tag),
        .restart        (rec.restart),
        .cfg_valid      (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .cmd            (cmd),
        .status         (status),
        .out_byte       (res.out_byte)
    );

endmodule

// ----- hdl/rre_checker.sv -----
// Port-level checker of the range record encoder and its bind to the top level.
module rre_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_last,
    input logic       out_error
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last)
                                    && $stable(out_error))
        else $error("result payload changed while stalled");

    // An error result is a lone zero byte that ends the record.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_error |-> out_last && (out_byte == 8'd0))
        else $error("error result is not a lone zero byte");

    // After a record is taken, no other record is taken and nothing is sent yet.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready && !out_valid)
        else $error("record accepted while another is in work");

    // Once the final result of a record is taken, the next record can enter.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> in_ready && !out_valid)
        else $error("encoder not idle after final result");

endmodule

bind range_record_encoder_top rre_checker u_rre_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rec.valid),
    .in_ready  (rec.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_byte  (res.out_byte),
    .out_last  (res.last),
    .out_error (res.error)
);

// ----- dv/range_record_encoder_top_tb.sv -----
// Self-checking testbench for the range record encoder: directed table, random records, checker.
module range_record_encoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rre_pkg::*;

    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          HOLD_CYCLES  = 300;
    localparam logic [63:0] NUM_LIMIT    = 64'h1000_0000_0000_0000;
    localparam logic [63:0] POS_LIMIT    = 64'h0800_0000_0000_0000;
    localparam logic [63:0] DELTA_LIMIT  = 64'h0400_0000_0000_0000;
    localparam logic [62:0] POS_ALL      = 63'h7FFF_FFFF_FFFF_FFFF;

    // Idle and stall percentages of the traffic phases.
    localparam int SEND_IDLE [4] = '{0, 88, 0, 7};
    localparam int RECV_STALL[4] = '{0, 0, 88, 7};

    typedef struct {
        logic [POS_W-1:0] pos;
        logic             hi;
        logic             ext;
        logic [63:0]      cnt;
        logic [63:0]      tag;
        logic             restart;
    } record_t;

    typedef struct {
        logic [7:0] out_byte;
        logic       last;
        logic       error;
    } byte_res_t;

    typedef struct {
        logic        off;
        logic        tg;
        record_t     r;
        int          lit_n;
        logic        lit_err;
        logic [31:0] lit;
    } table_row_t;

    logic clk;
    logic rst_n;

    rre_rec_if  rec ();
    rre_byte_if res ();
    rre_cfg_if  cfg ();

    range_record_encoder_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rec   (rec),
        .res   (res),
        .cfg   (cfg)
    );

    // Local copy of the encoder state and configuration.
    logic [63:0] run_end   = '0;
    logic        offset_on = 1'b0;
    logic        tag_on    = 1'b0;

    byte_res_t  expected_bytes[$];
    table_row_t dir_rows[$];
    byte_res_t  next_exp;
    int         mismatch_count = 0;
    int         cycle_count    = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         stall_left     = 0;
    logic       hold_req       = 1'b0;
    logic       hold_done      = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Appends one length-prefixed number: value shifted by 4, extra byte count in the low nibble.
    function automatic void push_number(ref byte_res_t q[$], input logic [63:0] v);
        logic [63:0] w;
        logic [63:0] rest;
        int          extra;
        w     = v << 4;
        rest  = w >> 8;
        extra = 0;
        while (rest != 0)
        begin
            extra++;
            rest = rest >> 8;
        end
        w = w | 64'(extra);
        for (int i = 0; i <= extra; i++)
        begin
            q.push_back(byte_res_t'{w[8*i +: 8], 1'b0, 1'b0});
        end
    endfunction

    // Computes the byte stream of one record and, for a good record, advances the running end.
    function automatic void encode_record(input record_t r, ref byte_res_t q[$]);
        logic [63:0] pos64;
        logic [63:0] endv;
        logic [63:0] d;
        logic [63:0] first;
        logic        bad;
        q.delete();
        pos64 = {1'b0, r.pos};
        endv  = r.restart ? 64'd0 : run_end;
        first = '0;
        bad   = (r.cnt >= NUM_LIMIT) || (tag_on && r.tag >= NUM_LIMIT);
        if (offset_on)
        begin
            if (pos64 < endv)
            begin
                bad = 1'b1;
            end
            else
            begin
                d = pos64 - endv;
                if (d >= DELTA_LIMIT)
                    bad = 1'b1;
                else
                    first = {d[61:0], r.hi, r.ext};
            end
        end
        else
        begin
            if (pos64 >= POS_LIMIT)
                bad = 1'b1;
            else
                first = {4'b0, r.pos[58:0], r.hi};
        end
        if (bad)
        begin
            // Dropped record: one error byte, state left alone.
            q.push_back(byte_res_t'{8'h00, 1'b1, 1'b1});
        end
        else
        begin
            push_number(q, first);
            push_number(q, r.cnt);
            if (!offset_on)
                q.push_back(byte_res_t'{{7'b0, r.ext}, 1'b0, 1'b0});
            if (tag_on)
                push_number(q, r.tag);
            q[q.size()-1].last = 1'b1;
            run_end = offset_on ? pos64 + r.cnt : endv;
        end
    endfunction

    function automatic void add_row(input int off, input int tg, input logic [62:0] pos,
                                    input int hi, input int ext, input logic [63:0] cnt,
                                    input logic [63:0] tag, input int rst, input int lit_n,
                                    input int lit_err, input logic [31:0] lit);
        table_row_t row;
        row.off     = 1'(off);
        row.tg      = 1'(tg);
        row.r       = '{pos, 1'(hi), 1'(ext), cnt, tag, 1'(rst)};
        row.lit_n   = lit_n;
        row.lit_err = 1'(lit_err);
        row.lit     = lit;
        dir_rows.push_back(row);
    endfunction

    // Random record, mostly well formed for the current mode, sometimes out of range.
    function automatic record_t make_record();
        record_t     r;
        logic [63:0] endv;
        r.hi      = 1'($urandom_range(1));
        r.ext     = 1'($urandom_range(1));
        r.restart = ($urandom_range(7) == 0) || (run_end[63:61] != 0);
        r.cnt     = rand64() >> $urandom_range(4, 63);
        r.tag     = rand64() >> $urandom_range(4, 63);
        endv      = r.restart ? 64'd0 : run_end;
        if (offset_on)
            r.pos = 63'(endv + (rand64() >> $urandom_range(6, 63)));
        else
            r.pos = 63'(rand64() >> $urandom_range(5, 63));
        if ($urandom_range(99) < 12)
        begin
            case ($urandom_range(3))
                0: r.pos = 63'(rand64());
                1: r.cnt = rand64();
                2: r.tag = rand64();
                default: r.pos = 63'((endv - 64'd1) >> $urandom_range(0, 8));
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offers one record and records its expected bytes once the transaction completes.
    task automatic offer_record(input record_t r, input int lit_n, input logic lit_err,
                                input logic [31:0] lit);
        int        gap;
        byte_res_t pred[$];
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            rec.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rec.position       <= r.pos;
        rec.high_flag      <= r.hi;
        rec.extension_flag <= r.ext;
        rec.range_count    <= r.cnt;
        rec.user_tag       <= r.tag;
        rec.restart        <= r.restart;
        rec.valid          <= 1'b1;
        @(posedge clk);
        while (!rec.ready)
            @(posedge clk);
        encode_record(r, pred);
        if (lit_n == 0)
        begin
            foreach (pred[k])
                expected_bytes.push_back(pred[k]);
        end
        else
        begin
            for (int k = 0; k < lit_n; k++)
                expected_bytes.push_back(byte_res_t'{lit[8*k +: 8], k == lit_n - 1, lit_err});
        end
    endtask

    // Stops offering records and lets the block run empty.
    task automatic wait_results_done();
        rec.valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= v;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        if (idx == CFG_OFFSET_MODE)
            offset_on = v[0];
        else if (idx == CFG_TAG_ENABLE)
            tag_on = v[0];
    endtask

    task automatic set_config(input logic off, input logic tg);
        wait_results_done();
        write_reg(CFG_OFFSET_MODE, off);
        write_reg(CFG_TAG_ENABLE, tg);
        cfg.valid <= 1'b0;
    endtask

    // Output ready: random stalls, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            stall_left = HOLD_CYCLES;
            hold_done  = 1'b1;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            res.ready <= 1'b0;
        end
        else
        begin
            res.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Checks each output transaction against the oldest expected byte.
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                report_mismatch("unexpected output byte", 64'(res.out_byte), 64'd0);
            end
            else
            begin
                next_exp = expected_bytes.pop_front();
                if (res.out_byte !== next_exp.out_byte)
                    report_mismatch("out_byte", 64'(res.out_byte), 64'(next_exp.out_byte));
                if (res.last !== next_exp.last)
                    report_mismatch("last", 64'(res.last), 64'(next_exp.last));
                if (res.error !== next_exp.error)
                    report_mismatch("error", 64'(res.error), 64'(next_exp.error));
            end
        end
    end

    // Run watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        rec.valid          = 1'b0;
        rec.position       = '0;
        rec.high_flag      = 1'b0;
        rec.extension_flag = 1'b0;
        rec.range_count    = '0;
        rec.user_tag       = '0;
        rec.restart        = 1'b0;
        cfg.valid          = 1'b0;
        cfg.index          = '0;
        cfg.data           = '0;

        // Plain mode, no tag: reset values, extremes, range errors, ignored tag.
        add_row(0, 0, 63'd0, 0, 0, 64'd0, 64'd0, 0, 3, 0, 32'h00_00_00);
        add_row(0, 0, 63'd0, 1, 1, 64'd0, 64'd0, 0, 3, 0, 32'h01_00_10);
        add_row(0, 0, 63'(POS_LIMIT - 1), 1, 0, NUM_LIMIT - 1, 64'd0, 0, 0, 0, '0);
        add_row(0, 0, 63'(POS_LIMIT), 0, 1, 64'd1, 64'd0, 0, 1, 1, '0);
        add_row(0, 0, POS_ALL, 1, 1, 64'd1, 64'd0, 0, 1, 1, '0);
        add_row(0, 0, 63'd9, 0, 0, NUM_LIMIT, 64'd0, 0, 1, 1, '0);
        add_row(0, 0, 63'd9, 0, 0, '1, 64'd0, 0, 1, 1, '0);
        add_row(0, 0, 63'd5, 1, 0, 64'd300, '1, 0, 0, 0, '0);
        add_row(0, 0, 63'd7, 0, 1, 64'd2, 64'd0, 1, 0, 0, '0);
        // Plain mode with tag.
        add_row(0, 1, 63'd1000, 0, 0, 64'd17, 64'd0, 0, 0, 0, '0);
        add_row(0, 1, 63'd3, 1, 1, 64'd4, NUM_LIMIT - 1, 0, 0, 0, '0);
        add_row(0, 1, 63'd3, 1, 1, 64'd4, NUM_LIMIT, 0, 1, 1, '0);
        add_row(0, 1, 63'd3, 0, 0, 64'd4, '1, 0, 1, 1, '0);
        // Offset mode: deltas, position below running end, restart on error.
        add_row(1, 0, 63'd0, 0, 0, 64'd0, 64'd0, 1, 0, 0, '0);
        add_row(1, 0, 63'd100, 1, 1, 64'd50, 64'd0, 0, 0, 0, '0);
        add_row(1, 0, 63'd149, 0, 0, 64'd1, 64'd0, 0, 1, 1, '0);
        add_row(1, 0, 63'(150 + DELTA_LIMIT), 0, 0, 64'd1, 64'd0, 0, 1, 1, '0);
        add_row(1, 0, 63'(150 + DELTA_LIMIT - 1), 1, 0, NUM_LIMIT - 1, '1, 0, 0, 0, '0);
        add_row(1, 0, 63'd0, 0, 1, NUM_LIMIT, 64'd0, 1, 1, 1, '0);
        add_row(1, 0, POS_ALL, 1, 1, 64'd0, 64'd0, 1, 1, 1, '0);
        add_row(1, 0, 63'd100, 0, 0, 64'd0, 64'd0, 0, 1, 1, '0);
        add_row(1, 0, 63'(DELTA_LIMIT - 1), 1, 1, NUM_LIMIT - 1, 64'd0, 1, 0, 0, '0);
        // Offset mode with tag.
        add_row(1, 1, 63'd0, 0, 0, 64'd0, NUM_LIMIT - 1, 1, 0, 0, '0);
        add_row(1, 1, 63'd5, 1, 0, 64'd3, NUM_LIMIT, 0, 1, 1, '0);
        add_row(1, 1, 63'd5, 0, 1, 64'd3, 64'd0, 0, 0, 0, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed table.
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].off != offset_on || dir_rows[i].tg != tag_on)
                set_config(dir_rows[i].off, dir_rows[i].tg);
            offer_record(dir_rows[i].r, dir_rows[i].lit_n, dir_rows[i].lit_err,
                         dir_rows[i].lit);
        end

        // Long output hold-off with records offered back to back, then a full pause.
        hold_req = 1'b1;
        repeat (12) offer_record(make_record(), 0, 1'b0, '0);
        wait_results_done();

        // Random records across all configurations and traffic phases.
        for (int s = 0; s < 8; s++)
        begin
            set_config(s[0] ^ s[2], s[1]);
            send_idle_pct  = SEND_IDLE[s % 4];
            recv_stall_pct = RECV_STALL[s % 4];
            repeat (40) offer_record(make_record(), 0, 1'b0, '0);
        end

        wait_results_done();
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
